@@ design/mcr_pkg.sv @@
// Package for the midpoint circle rasterizer: field widths, defaults and
// the command/status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package mcr_pkg;

  localparam int unsigned MAX_RADIUS = 40;
  localparam int unsigned COORD_BITS = 10;

  localparam int unsigned CRD_W = 10;  // center coordinate word
  localparam int unsigned RAD_W = 6;   // radius word
  localparam int unsigned PT_W  = 12;  // signed point coordinate
  localparam int unsigned OFF_W = 7;   // signed x/y offset
  localparam int unsigned STP_W = 8;   // dx/dy step
  localparam int unsigned ERR_W = 10;  // signed error term

  typedef struct packed {
    logic load;     // capture a new circle
    logic advance;  // step the iteration after the second half
    logic half;     // which half of the current octant set is shown
  } mcr_cmd_t;

  typedef struct packed {
    logic zero_rad;   // incoming radius is zero, nothing to draw
    logic last_iter;  // the pending step ends the circle
  } mcr_sts_t;

endpackage

@@ design/mcr_if.sv @@
// Handshake channels for circle requests and point results.
// Depends on mcr_pkg.
`timescale 1ns / 1ps

interface mcr_req_if;
  import mcr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CRD_W-1:0] center_x;
  logic [CRD_W-1:0] center_y;
  logic [RAD_W-1:0] radius;

  modport source (output valid, center_x, center_y, radius, input ready);
  modport sink   (input valid, center_x, center_y, radius, output ready);
endinterface

interface mcr_res_if;
  import mcr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] pt0_x;
  logic signed [PT_W-1:0] pt0_y;
  logic signed [PT_W-1:0] pt1_x;
  logic signed [PT_W-1:0] pt1_y;
  logic signed [PT_W-1:0] pt2_x;
  logic signed [PT_W-1:0] pt2_y;
  logic signed [PT_W-1:0] pt3_x;
  logic signed [PT_W-1:0] pt3_y;
  logic                   second_half;
  logic                   last_result;

  modport source (output valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y,
                  pt3_x, pt3_y, second_half, last_result, input ready);
  modport sink   (input valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y,
                  pt3_x, pt3_y, second_half, last_result, output ready);
endinterface

@@ design/mcr_ctrl.sv @@
// Controller of the midpoint circle rasterizer: sequences load, the two
// half words of each iteration and the step. Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mcr_pkg::mcr_sts_t sts_i,
  output mcr_pkg::mcr_cmd_t cmd_o
);
  import mcr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HALF0 = 2'd1;
  localparam logic [1:0] S_HALF1 = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.zero_rad) state_d = S_HALF0;
        end
      end
      S_HALF0: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_HALF1;
      end
      S_HALF1: begin
        out_valid_o = 1'b1;
        cmd_o.half  = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.last_iter ? S_IDLE : S_HALF0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/mcr_datapath.sv @@
// Datapath of the midpoint circle rasterizer: held circle, x/y offsets,
// steps, error term and the eight mirrored points. Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_datapath #(
  parameter int unsigned MaxRadius = mcr_pkg::MAX_RADIUS,
  parameter int unsigned CoordBits = mcr_pkg::COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mcr_pkg::CRD_W-1:0]      center_x_i,
  input  logic [mcr_pkg::CRD_W-1:0]      center_y_i,
  input  logic [mcr_pkg::RAD_W-1:0]      radius_i,
  input  mcr_pkg::mcr_cmd_t              cmd_i,
  output mcr_pkg::mcr_sts_t              sts_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt0_x_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt0_y_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt1_x_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt1_y_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt2_x_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt2_y_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt3_x_o,
  output logic signed [mcr_pkg::PT_W-1:0] pt3_y_o,
  output logic                           second_half_o,
  output logic                           last_result_o
);
  import mcr_pkg::*;

  localparam int unsigned MaskBits = (CoordBits < CRD_W) ? CoordBits : CRD_W;
  localparam logic [CRD_W-1:0] CoordMask = CRD_W'((64'd1 << MaskBits) - 64'd1);

  logic [CRD_W-1:0]        cx_q, cy_q;
  logic [OFF_W-1:0]        rad2_q;
  logic signed [OFF_W-1:0] x_q, y_q, x_n, y_n;
  logic [STP_W-1:0]        dx_q, dy_q, dx_n, dy_n;
  logic signed [ERR_W-1:0] err_q, err_a, err_n;
  logic [RAD_W-1:0]        rad_sat;

  assign rad_sat = (radius_i > RAD_W'(MaxRadius)) ? RAD_W'(MaxRadius) : radius_i;
  assign sts_o.zero_rad = (rad_sat == '0);

  // one midpoint step: maybe move y, then maybe move x
  always_comb begin
    y_n   = y_q;
    dy_n  = dy_q;
    err_a = err_q;
    if (err_q <= 0) begin
      y_n   = y_q + OFF_W'(1);
      err_a = err_q + ERR_W'(dy_q);
      dy_n  = dy_q + STP_W'(2);
    end
    x_n   = x_q;
    dx_n  = dx_q;
    err_n = err_a;
    if (err_a > 0) begin
      x_n   = x_q - OFF_W'(1);
      dx_n  = dx_q + STP_W'(2);
      err_n = err_a + ERR_W'(dx_n) - ERR_W'(rad2_q);
    end
  end

  assign sts_o.last_iter = (x_n < y_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      rad2_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      dx_q   <= STP_W'(1);
      dy_q   <= STP_W'(1);
      err_q  <= '0;
    end else if (cmd_i.load) begin
      cx_q   <= center_x_i & CoordMask;
      cy_q   <= center_y_i & CoordMask;
      rad2_q <= {rad_sat, 1'b0};
      x_q    <= OFF_W'(rad_sat) - OFF_W'(1);
      y_q    <= '0;
      dx_q   <= STP_W'(1);
      dy_q   <= STP_W'(1);
      err_q  <= ERR_W'(1) - ERR_W'({rad_sat, 1'b0});
    end else if (cmd_i.advance) begin
      x_q   <= x_n;
      y_q   <= y_n;
      dx_q  <= dx_n;
      dy_q  <= dy_n;
      err_q <= err_n;
    end
  end

  // mirrored points
  logic signed [PT_W-1:0] cxe, cye, xe, ye;

  assign cxe = signed'(PT_W'(cx_q));
  assign cye = signed'(PT_W'(cy_q));
  assign xe  = PT_W'(x_q);
  assign ye  = PT_W'(y_q);

  always_comb begin
    if (!cmd_i.half) begin
      pt0_x_o = cxe + xe; pt0_y_o = cye + ye;
      pt1_x_o = cxe + ye; pt1_y_o = cye + xe;
      pt2_x_o = cxe - xe; pt2_y_o = cye + ye;
      pt3_x_o = cxe - ye; pt3_y_o = cye + xe;
    end else begin
      pt0_x_o = cxe - xe; pt0_y_o = cye - ye;
      pt1_x_o = cxe - ye; pt1_y_o = cye - xe;
      pt2_x_o = cxe + ye; pt2_y_o = cye - xe;
      pt3_x_o = cxe + xe; pt3_y_o = cye - ye;
    end
  end

  assign second_half_o = cmd_i.half;
  assign last_result_o = cmd_i.half & sts_o.last_iter;

endmodule

@@ design/midpoint_circle_rasterizer.sv @@
// Midpoint circle rasterizer, top level. Depends on mcr_pkg, mcr_if,
// mcr_ctrl and mcr_datapath.
// The first word follows in the cycle after the request is taken; then one word a cycle
// while the sink is ready. A circle gives two words per iteration (about r/sqrt2+1),
// and no request is taken until its last word leaves. A zero radius gives no words.
// Reset (rst_ni, async low): controller idle and ready, iteration state reset.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer #(
  parameter int unsigned MaxRadius = mcr_pkg::MAX_RADIUS,
  parameter int unsigned CoordBits = mcr_pkg::COORD_BITS
) (
  input logic       clk_i,
  input logic       rst_ni,
  mcr_req_if.sink   req_i,
  mcr_res_if.source res_o
);
  import mcr_pkg::*;

  mcr_cmd_t cmd;
  mcr_sts_t sts;

  // Controller: idle takes a request word, then walks half 0 / half 1 of
  // each iteration; the step happens when the second half word leaves.
  mcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: every point comes from registers through one adder and the flags
  // from the state and step logic, so the word stays stable while the sink stalls.
  mcr_datapath #(
    .MaxRadius (MaxRadius),
    .CoordBits (CoordBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .center_x_i    (req_i.center_x),
    .center_y_i    (req_i.center_y),
    .radius_i      (req_i.radius),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pt0_x_o       (res_o.pt0_x),
    .pt0_y_o       (res_o.pt0_y),
    .pt1_x_o       (res_o.pt1_x),
    .pt1_y_o       (res_o.pt1_y),
    .pt2_x_o       (res_o.pt2_x),
    .pt2_y_o       (res_o.pt2_y),
    .pt3_x_o       (res_o.pt3_x),
    .pt3_y_o       (res_o.pt3_y),
    .second_half_o (res_o.second_half),
    .last_result_o (res_o.last_result)
  );

`ifndef NO_ASSERTIONS
  // never take a request while a circle is still being drawn
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && res_o.valid))
    else $error("request accepted while drawing");

  // only the second half word may close a circle
  a_last_in_half1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.last_result) |-> res_o.second_half)
    else $error("last word outside second half");

  // a first-half word is always followed by its second half
  a_pairing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.second_half) |=>
    (res_o.valid && res_o.second_half))
    else $error("half pairing broken");

  // after the closing word the block is ready again
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.last_result) |=> req_i.ready)
    else $error("not idle after last word");
`endif

endmodule

@@ tb/sv/tb_midpoint_circle_rasterizer.sv @@
// Self-checking bench for midpoint_circle_rasterizer: directed and random circles,
// with every point word checked against a behavioral circle tracer or typed-in results.
// Depends on mcr_pkg, mcr_if and the rasterizer RTL.
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer;
  import mcr_pkg::*;

  localparam int unsigned RANDOM_CIRCLES = 140;
  localparam int unsigned WORDS_PER_CIRCLE_MAX = 64;  // tracer cap, never hit at r <= 40
  localparam int unsigned HOLD_AT_CIRCLE = 40;        // long sink hold-off starts here
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;         // cycles with no word moved
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned REPORT_MAX = 10;

  // Directed rows: single-pixel circles and zero radius have their results typed
  // in; everything else goes through the tracer.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_POINTS,
    ROW_SINGLE_PIXEL
  } row_kind_e;

  typedef struct packed {
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    logic [RAD_W-1:0] r;
    row_kind_e        kind;
  } circle_row_t;

  // One result word: pt[0] = pt0_x, pt[1] = pt0_y, ... pt[7] = pt3_y.
  typedef struct packed {
    logic [7:0][PT_W-1:0] pt;
    logic                 second_half;
    logic                 last_result;
  } point_word_t;

  circle_row_t directed_rows [19] = '{
    '{10'd0,    10'd0,    6'd1,  ROW_SINGLE_PIXEL},  // smallest circle at the origin
    '{10'd1023, 10'd1023, 6'd1,  ROW_SINGLE_PIXEL},  // smallest circle at the far corner
    '{10'd512,  10'd512,  6'd0,  ROW_NO_POINTS},     // zero radius: nothing drawn
    '{10'd0,    10'd0,    6'd40, ROW_PREDICT},       // widest circle, negative coords
    '{10'd1023, 10'd1023, 6'd40, ROW_PREDICT},       // widest circle, coords past 1023
    '{10'd0,    10'd1023, 6'd40, ROW_PREDICT},
    '{10'd1023, 10'd0,    6'd40, ROW_PREDICT},
    '{10'd0,    10'd0,    6'd0,  ROW_NO_POINTS},
    '{10'd1023, 10'd1023, 6'd63, ROW_PREDICT},       // radius clamps to MAX_RADIUS
    '{10'd100,  10'd200,  6'd41, ROW_PREDICT},       // just above the clamp
    '{10'd300,  10'd300,  6'd32, ROW_PREDICT},
    '{10'h2AA,  10'h155,  6'h15, ROW_PREDICT},       // alternating bit patterns
    '{10'h155,  10'h2AA,  6'h2A, ROW_PREDICT},
    '{10'd5,    10'd5,    6'd2,  ROW_PREDICT},
    '{10'd7,    10'd9,    6'd3,  ROW_PREDICT},
    '{10'd1023, 10'd0,    6'd0,  ROW_NO_POINTS},
    '{10'd600,  10'd20,   6'd4,  ROW_PREDICT},
    '{10'd20,   10'd600,  6'd5,  ROW_PREDICT},
    '{10'd1,    10'd1,    6'd1,  ROW_SINGLE_PIXEL}
  };

  logic clk_i;
  logic rst_ni;

  mcr_req_if req_ch ();
  mcr_res_if res_ch ();

  midpoint_circle_rasterizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  point_word_t queued_point_words[$];
  int unsigned circles_taken = 0;
  int unsigned empty_circles = 0;
  int unsigned clamped_circles = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Four of the eight symmetric points of (x, y) around the center, as one half word.
  function automatic point_word_t octant_word(input int cx, input int cy, input int x,
                                              input int y, input bit half);
    point_word_t w;
    if (!half) begin
      w.pt[0] = PT_W'(cx + x); w.pt[1] = PT_W'(cy + y);
      w.pt[2] = PT_W'(cx + y); w.pt[3] = PT_W'(cy + x);
      w.pt[4] = PT_W'(cx - x); w.pt[5] = PT_W'(cy + y);
      w.pt[6] = PT_W'(cx - y); w.pt[7] = PT_W'(cy + x);
    end else begin
      w.pt[0] = PT_W'(cx - x); w.pt[1] = PT_W'(cy - y);
      w.pt[2] = PT_W'(cx - y); w.pt[3] = PT_W'(cy - x);
      w.pt[4] = PT_W'(cx + y); w.pt[5] = PT_W'(cy - x);
      w.pt[6] = PT_W'(cx + x); w.pt[7] = PT_W'(cy - y);
    end
    w.second_half = half;
    w.last_result = 1'b0;
    return w;
  endfunction

  // Midpoint circle walk: queues the two half words of every iteration, marks
  // the final word of the circle. A zero radius queues nothing.
  task automatic trace_circle(input logic [CRD_W-1:0] cx_in, input logic [CRD_W-1:0] cy_in,
                              input logic [RAD_W-1:0] r_in);
    int cx, cy, r, x, y, dx, dy, err, words;
    cx = int'(cx_in) & ((1 << COORD_BITS) - 1);
    cy = int'(cy_in) & ((1 << COORD_BITS) - 1);
    r = (int'(r_in) > MAX_RADIUS) ? MAX_RADIUS : int'(r_in);
    if (r == 0) return;
    x = r - 1;
    y = 0;
    dx = 1;
    dy = 1;
    err = dx - 2 * r;
    words = 0;
    while (x >= y && words + 2 <= WORDS_PER_CIRCLE_MAX) begin
      queued_point_words.push_back(octant_word(cx, cy, x, y, 1'b0));
      queued_point_words.push_back(octant_word(cx, cy, x, y, 1'b1));
      words += 2;
      if (err <= 0) begin
        y++;
        err += dy;
        dy += 2;
      end
      if (err > 0) begin
        x--;
        dx += 2;
        err += dx - 2 * r;
      end
    end
    queued_point_words[queued_point_words.size() - 1].last_result = 1'b1;
  endtask

  // Radius 1 collapses to the center: two words, all eight points on it.
  task automatic queue_single_pixel(input logic [CRD_W-1:0] cx, input logic [CRD_W-1:0] cy);
    point_word_t w;
    for (int i = 0; i < 8; i++) w.pt[i] = (i % 2) ? PT_W'(cy) : PT_W'(cx);
    w.second_half = 1'b0;
    w.last_result = 1'b0;
    queued_point_words.push_back(w);
    w.second_half = 1'b1;
    w.last_result = 1'b1;
    queued_point_words.push_back(w);
  endtask

  // Offer one circle after an optional gap (noise on the payload meanwhile),
  // return at the edge that takes it.
  task automatic send_circle(input logic [CRD_W-1:0] cx, input logic [CRD_W-1:0] cy,
                             input logic [RAD_W-1:0] r, input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      req_ch.valid    <= 1'b0;
      req_ch.center_x <= CRD_W'($urandom);
      req_ch.center_y <= CRD_W'($urandom);
      req_ch.radius   <= RAD_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid    <= 1'b1;
    req_ch.center_x <= cx;
    req_ch.center_y <= cy;
    req_ch.radius   <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    circles_taken++;
    if (r == 0) empty_circles++;
    if (r > MAX_RADIUS) clamped_circles++;
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] MISMATCH word %0d: %s", $time,
                                           words_checked, msg);
  endtask

  // Result sink: ready idles at random, calm stretches come and go, and once
  // it holds off long enough that the block backs up into its request side.
  initial begin
    int unsigned stall_left, hold_left;
    bit calm, held_off;
    res_ch.ready = 1'b0;
    stall_left = 0;
    hold_left = 0;
    calm = 1'b0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && circles_taken >= HOLD_AT_CIRCLE) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(49) == 0) calm = !calm;
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = pick_gap(calm);
      end
    end
  end

  // Checker: each accepted word against the oldest queued word, field by field.
  always @(posedge clk_i) begin
    point_word_t got, want;
    if (rst_ni === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.pt[0] = res_ch.pt0_x; got.pt[1] = res_ch.pt0_y;
      got.pt[2] = res_ch.pt1_x; got.pt[3] = res_ch.pt1_y;
      got.pt[4] = res_ch.pt2_x; got.pt[5] = res_ch.pt2_y;
      got.pt[6] = res_ch.pt3_x; got.pt[7] = res_ch.pt3_y;
      got.second_half = res_ch.second_half;
      got.last_result = res_ch.last_result;
      if (queued_point_words.size() == 0) begin
        log_mismatch($sformatf("unexpected word, pt0 (%0d,%0d)", $signed(got.pt[0]),
                               $signed(got.pt[1])));
      end else begin
        want = queued_point_words.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got.pt[i] !== want.pt[i])
            log_mismatch($sformatf("pt%0d_%s expected %0d, got %0d", i / 2,
                                   (i % 2) ? "y" : "x", $signed(want.pt[i]),
                                   $signed(got.pt[i])));
        end
        if (got.second_half !== want.second_half)
          log_mismatch($sformatf("second_half expected %0b, got %0b", want.second_half,
                                 got.second_half));
        if (got.last_result !== want.last_result)
          log_mismatch($sformatf("last_result expected %0b, got %0b", want.last_result,
                                 got.last_result));
      end
      words_checked++;
    end
  end

  // Watchdog: too long without a word moving on either channel ends the run.
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] timeout: no word moved for %0d cycles, %0d words outstanding", $time,
             STALL_LIMIT, queued_point_words.size());
    $display("tb_midpoint_circle_rasterizer: errors");
    $finish;
  end

  // Stimulus: directed table, then random circles, then drain and verdict.
  initial begin
    circle_row_t row;
    logic [CRD_W-1:0] cx, cy;
    logic [RAD_W-1:0] r;
    int unsigned roll;
    req_ch.valid = 1'b0;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    req_ch.radius = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_circle(row.cx, row.cy, row.r, pick_gap(1'b0));
      case (row.kind)
        ROW_SINGLE_PIXEL: queue_single_pixel(row.cx, row.cy);
        ROW_NO_POINTS: ;
        default: trace_circle(row.cx, row.cy, row.r);
      endcase
    end

    // Mostly small radii to keep circles short, a handful of wide ones,
    // plus the odd zero and out-of-range radius.
    for (int n = 0; n < RANDOM_CIRCLES; n++) begin
      roll = $urandom_range(99);
      if (roll < 3) r = '0;
      else if (roll < 7) r = RAD_W'($urandom_range(63, MAX_RADIUS + 1));
      else if (roll < 17) r = RAD_W'($urandom_range(MAX_RADIUS, 30));
      else r = RAD_W'($urandom_range(12, 1));
      cx = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : CRD_W'($urandom);
      cy = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : CRD_W'($urandom);
      send_circle(cx, cy, r, pick_gap(((n / 25) % 2) == 1));
      trace_circle(cx, cy, r);
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;

    // Leftover words keep the queue non-empty and end in the watchdog.
    while (queued_point_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d circles (%0d zero radius, %0d clamped radius)",
             circles_taken, empty_circles, clamped_circles);
    $display("%0d point words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_midpoint_circle_rasterizer: clean");
    end else begin
      $display("tb_midpoint_circle_rasterizer: errors");
    end
    $finish;
  end

endmodule
